>>> hdl/pcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared widths, codes, reset values and state encoding of the partition
// claim dispenser.
// ----------------------------------------------------------------------------
package pcd_pkg;

  // Default sizing of the claim map and thread tables
  localparam int DEF_MAX_PARTITIONS = 1024;
  localparam int DEF_MAX_THREADS    = 64;

  // Configuration port
  localparam int PC_W       = 11;
  localparam int TC_W       = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [PC_W-1:0] PC_RESET = 11'd64;
  localparam logic [TC_W-1:0] TC_RESET = 7'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PARTITION_COUNT = 1'b0,
    CFG_THREAD_COUNT    = 1'b1
  } pcd_cfg_idx_e;

  // Request and response fields
  localparam int MODE_W  = 1;
  localparam int TID_W   = 6;
  localparam int PREV_W  = 11;
  localparam int PART_W  = 10;
  localparam int OWNER_W = 6;
  localparam int LEFT_W  = 11;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLAIM     = 1'b0,
    MODE_NEW_ROUND = 1'b1
  } pcd_mode_e;

  // Claim map word geometry
  localparam int WORD_W  = 32;
  localparam int WORD_BW = 5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_START_WAIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_OWN_RD,
    ST_OWN_CMP,
    ST_LEFT_WR,
    ST_EMIT
  } pcd_state_e;

endpackage

>>> hdl/pcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_if
// Valid/ready channels of the dispenser: request channel and response channel.
// ----------------------------------------------------------------------------
interface pcd_req_if;
  import pcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [TID_W-1:0]  thread_id;
  logic [PREV_W-1:0] prev_partition;

  modport source (output valid, mode, thread_id, prev_partition, input ready);
  modport sink   (input valid, mode, thread_id, prev_partition, output ready);
endinterface

interface pcd_rsp_if;
  import pcd_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [PART_W-1:0]  partition;
  logic [OWNER_W-1:0] owner_thread;
  logic [LEFT_W-1:0]  owner_left;
  logic [LEFT_W-1:0]  partitions_left;

  modport source (output valid, found, partition, owner_thread, owner_left,
                  partitions_left, input ready);
  modport sink   (input valid, found, partition, owner_thread, owner_left,
                  partitions_left, output ready);
endinterface

>>> hdl/pcd_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_divider
// Restoring divider, one quotient bit per cycle, for the per-thread quota.
// ----------------------------------------------------------------------------
module pcd_divider #(
  parameter int  MAX_PARTITIONS = pcd_pkg::DEF_MAX_PARTITIONS,
  parameter int  MAX_THREADS    = pcd_pkg::DEF_MAX_THREADS,
  localparam int CW             = $clog2(MAX_PARTITIONS + 1),
  localparam int RTW            = $clog2(MAX_THREADS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [CW-1:0]  dividend_i,
  input  logic [RTW-1:0] divisor_i,
  output logic           done_o,
  output logic [CW-1:0]  quotient_o
);
  import pcd_pkg::*;

  localparam int SCW = $clog2(CW + 1);

  logic [CW-1:0]  quo_q, quo_d;
  logic [RTW-1:0] rem_q, rem_d;
  logic [RTW-1:0] dsr_q, dsr_d;
  logic [SCW-1:0] cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [RTW:0]   trial;
  logic           qbit;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    trial  = {rem_q, quo_q[CW-1]};
    qbit   = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        qbit  = 1'b1;
        rem_d = RTW'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[RTW-1:0];
      end
      quo_d = {quo_q[CW-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == SCW'(CW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> hdl/partition_claim_dispenser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_claim_dispenser_core
// Hands out partitions to worker threads from a word-wide claim map, and
// rebuilds the per-thread ranges at the start of each round.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  -------   ---  ---------          -------
//  req_i     in   valid/ready        mode, thread_id, prev_partition
//  rsp_o     out  valid/ready        found, partition, owner_thread,
//                                    owner_left, partitions_left
//  cfg       in   cfg_we_i (no wait) cfg_idx_i, cfg_wdata_i
//
//  A claim visits the 32-bit map words one per cycle from the map RAM port;
//  the owner lookup is then a binary search over the range-end table.
//  A new round clears the map at one word per cycle, then runs the
//  one-bit-per-cycle quota divider once for each thread of the round.
//  One request at a time: ready is high only in the idle state. A finished
//  response waits in the output register and the next request may be taken
//  meanwhile; a new response is held back until the old one is taken.
//  Reset clears control state only; the map is cleared at each new round and
//  claims before the first round report not found.
// ----------------------------------------------------------------------------
module partition_claim_dispenser_core #(
  parameter int  MAX_PARTITIONS = pcd_pkg::DEF_MAX_PARTITIONS,
  parameter int  MAX_THREADS    = pcd_pkg::DEF_MAX_THREADS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pcd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pcd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  pcd_req_if.sink                        req_i,
  pcd_rsp_if.source                      rsp_o
);
  import pcd_pkg::*;

  // Widths that follow from the sizing
  localparam int CW     = $clog2(MAX_PARTITIONS + 1);   // partition counts
  localparam int PW     = $clog2(MAX_PARTITIONS);       // partition index
  localparam int RTW    = $clog2(MAX_THREADS + 1);      // thread counts
  localparam int TW     = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int NWORDS = (MAX_PARTITIONS + WORD_W - 1) / WORD_W;
  localparam int WA     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int IX     = WA + WORD_BW;                 // word address + bit

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [PC_W-1:0] pc_q;
  logic [TC_W-1:0] tc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_RESET;
      tc_q <= TC_RESET;
    end else if (cfg_we_i) begin
      unique case (pcd_cfg_idx_e'(cfg_idx_i))
        CFG_PARTITION_COUNT: pc_q <= cfg_wdata_i[PC_W-1:0];
        CFG_THREAD_COUNT:    tc_q <= cfg_wdata_i[TC_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturated counts, with zero threads taken as one, latched at the next new round
  logic [CW-1:0]  rp_new;
  logic [RTW-1:0] rt_new;

  always_comb begin
    if (32'(pc_q) > MAX_PARTITIONS) begin
      rp_new = CW'(MAX_PARTITIONS);
    end else begin
      rp_new = CW'(pc_q);
    end
    if (32'(tc_q) > MAX_THREADS) begin
      rt_new = RTW'(MAX_THREADS);
    end else if (tc_q == '0) begin
      rt_new = RTW'(1);
    end else begin
      rt_new = RTW'(tc_q);
    end
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  pcd_state_e     state_q, state_d;
  logic [CW-1:0]  rp_q, rp_d;             // partitions this round
  logic [RTW-1:0] rt_q, rt_d;             // threads this round
  logic [IX-1:0]  rpm1_q, rpm1_d;         // last partition index this round
  logic [TW-1:0]  rtm1_q, rtm1_d;         // last thread index this round
  logic [CW-1:0]  pending_q, pending_d;
  logic           out_valid_q, out_valid_d;

  // Sequencer working registers (payload, no reset)
  logic [WA-1:0]      cw_q, cw_d;         // map word under scan or clear
  logic [WA-1:0]      w0_q, w0_d;         // word of the scan start
  logic [WORD_BW-1:0] off_q, off_d;       // bit of the scan start
  logic               wrap_q, wrap_d;
  logic [TW-1:0]      t_q, t_d;
  logic [CW-1:0]      lparts_q, lparts_d;
  logic [RTW-1:0]     lthr_q, lthr_d;
  logic [CW-1:0]      offset_q, offset_d;
  logic [IX-1:0]      part_q, part_d;
  logic [TW-1:0]      lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic               found_q, found_d;
  logic [CW-1:0]      oleft_q, oleft_d;

  // Output register
  logic               out_found_q;
  logic [PART_W-1:0]  out_part_q;
  logic [OWNER_W-1:0] out_owner_q;
  logic [LEFT_W-1:0]  out_oleft_q;
  logic [LEFT_W-1:0]  out_pleft_q;
  logic               out_load;

  // --------------------------------------------------------------------------
  // Memories: claim map words and the three thread tables
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] map_mem [NWORDS];
  logic [PW-1:0]     start_mem [MAX_THREADS];
  logic [CW-1:0]     end_mem [MAX_THREADS];
  logic [CW-1:0]     left_mem [MAX_THREADS];

  logic              map_we;
  logic [WA-1:0]     map_wa, map_ra;
  logic [WORD_W-1:0] map_wd, map_rd_q;
  logic              rng_we;
  logic [TW-1:0]     rng_wa;
  logic [PW-1:0]     start_wd, start_rd_q;
  logic [CW-1:0]     end_wd, end_rd_q;
  logic              left_we;
  logic [TW-1:0]     left_wa, start_ra, end_ra, left_ra;
  logic [CW-1:0]     left_wd, left_rd_q;

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_rd_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rng_we) begin
      start_mem[rng_wa] <= start_wd;
      end_mem[rng_wa]   <= end_wd;
    end
    start_rd_q <= start_mem[start_ra];
    end_rd_q   <= end_mem[end_ra];
  end

  always_ff @(posedge clk_i) begin
    if (left_we) begin
      left_mem[left_wa] <= left_wd;
    end
    left_rd_q <= left_mem[left_ra];
  end

  // --------------------------------------------------------------------------
  // Quota divider
  // --------------------------------------------------------------------------
  logic          div_start;
  logic          div_done;
  logic [CW-1:0] div_quo;

  pcd_divider #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .MAX_THREADS    (MAX_THREADS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lparts_q),
    .divisor_i  (lthr_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // --------------------------------------------------------------------------
  // Scan datapath: mask the fetched word to the live window, find first free
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0]  lim_mask, pos_mask, avail;
  logic               scan_hit;
  logic [WORD_BW-1:0] scan_idx;
  logic [WA-1:0]      last_w, cw_nxt;

  assign last_w = rpm1_q[IX-1:WORD_BW];

  always_comb begin
    // Drop bits beyond the round's last partition
    if (cw_q == last_w) begin
      lim_mask = {WORD_W{1'b1}} >> (WORD_BW'(WORD_W - 1) - rpm1_q[WORD_BW-1:0]);
    end else begin
      lim_mask = {WORD_W{1'b1}};
    end
    // First visit of the start word covers bits from the start onward; the
    // revisit after wrapping covers the bits below it
    if (cw_q == w0_q) begin
      if (wrap_q) begin
        pos_mask = ~({WORD_W{1'b1}} << off_q);
      end else begin
        pos_mask = {WORD_W{1'b1}} << off_q;
      end
    end else begin
      pos_mask = {WORD_W{1'b1}};
    end
    avail    = ~map_rd_q & lim_mask & pos_mask;
    scan_hit = |avail;
    scan_idx = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (avail[j]) begin
        scan_idx = WORD_BW'(j);
      end
    end
    if (cw_q == last_w) begin
      cw_nxt = '0;
    end else begin
      cw_nxt = cw_q + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic          req_fire;
  logic          prev_oor;
  logic          tid_own;
  logic [IX-1:0] p0;
  logic [TW:0]   lo_hi_sum;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign prev_oor    = 32'(req_i.prev_partition) >= 32'(rp_q);
  assign tid_own     = 32'(req_i.thread_id) < 32'(rt_q);
  assign lo_hi_sum   = {1'b0, lo_q} + {1'b0, hi_q};

  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    rt_d        = rt_q;
    rpm1_d      = rpm1_q;
    rtm1_d      = rtm1_q;
    pending_d   = pending_q;
    cw_d        = cw_q;
    w0_d        = w0_q;
    off_d       = off_q;
    wrap_d      = wrap_q;
    t_d         = t_q;
    lparts_d    = lparts_q;
    lthr_d      = lthr_q;
    offset_d    = offset_q;
    part_d      = part_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    found_d     = found_q;
    oleft_d     = oleft_q;
    out_load    = 1'b0;
    div_start   = 1'b0;
    p0          = '0;
    map_we      = 1'b0;
    map_wa      = cw_q;
    map_wd      = '0;
    map_ra      = cw_q;
    rng_we      = 1'b0;
    rng_wa      = t_q;
    start_wd    = PW'(offset_q);
    end_wd      = offset_q + div_quo;
    left_we     = 1'b0;
    left_wa     = t_q;
    left_wd     = div_quo;
    start_ra    = TW'(req_i.thread_id);
    end_ra      = mid_q;
    left_ra     = lo_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          found_d = 1'b0;
          part_d  = '0;
          oleft_d = '0;
          lo_d    = '0;
          if (req_i.mode == MODE_NEW_ROUND) begin
            // Latch the counts and start the clearing sweep
            rp_d      = rp_new;
            rt_d      = rt_new;
            rpm1_d    = (rp_new == '0) ? '0 : IX'(rp_new - 1'b1);
            rtm1_d    = TW'(rt_new - 1'b1);
            pending_d = rp_new;
            lparts_d  = rp_new;
            lthr_d    = rt_new;
            offset_d  = '0;
            t_d       = '0;
            cw_d      = '0;
            state_d   = ST_CLEAR;
          end else if (pending_q == '0 || rp_q == '0) begin
            state_d = ST_EMIT;
          end else if (prev_oor && tid_own) begin
            // Start from the thread's own range; read issued this edge
            state_d = ST_START_WAIT;
          end else begin
            if (!prev_oor) begin
              p0 = IX'(req_i.prev_partition);
            end
            w0_d    = p0[IX-1:WORD_BW];
            off_d   = p0[WORD_BW-1:0];
            cw_d    = p0[IX-1:WORD_BW];
            wrap_d  = 1'b0;
            state_d = ST_SCAN_RD;
          end
        end
      end

      ST_CLEAR: begin
        map_we = 1'b1;
        map_wd = '0;
        if (cw_q == WA'(NWORDS - 1)) begin
          state_d = ST_DIV_START;
        end else begin
          cw_d = cw_q + 1'b1;
        end
      end

      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end

      ST_DIV_WAIT: begin
        if (div_done) begin
          rng_we   = 1'b1;
          left_we  = 1'b1;
          offset_d = offset_q + div_quo;
          lparts_d = lparts_q - div_quo;
          lthr_d   = lthr_q - 1'b1;
          if (t_q == rtm1_q) begin
            state_d = ST_EMIT;
          end else begin
            t_d     = t_q + 1'b1;
            state_d = ST_DIV_START;
          end
        end
      end

      ST_START_WAIT: begin
        p0      = IX'(start_rd_q);
        w0_d    = p0[IX-1:WORD_BW];
        off_d   = p0[WORD_BW-1:0];
        cw_d    = p0[IX-1:WORD_BW];
        wrap_d  = 1'b0;
        state_d = ST_SCAN_RD;
      end

      ST_SCAN_RD: begin
        map_ra  = cw_q;
        state_d = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        if (scan_hit) begin
          // Claim the bit and start the owner search
          map_we    = 1'b1;
          map_wa    = cw_q;
          map_wd    = map_rd_q | (WORD_W'(1) << scan_idx);
          part_d    = {cw_q, scan_idx};
          pending_d = pending_q - 1'b1;
          found_d   = 1'b1;
          lo_d      = '0;
          hi_d      = rtm1_q;
          state_d   = ST_OWN_RD;
        end else begin
          // Fetch the next word straight away
          map_ra = cw_nxt;
          cw_d   = cw_nxt;
          if (cw_q == last_w) begin
            wrap_d = 1'b1;
          end
        end
      end

      ST_OWN_RD: begin
        if (lo_q == hi_q) begin
          left_ra = lo_q;
          state_d = ST_LEFT_WR;
        end else begin
          mid_d   = lo_hi_sum[TW:1];
          end_ra  = lo_hi_sum[TW:1];
          state_d = ST_OWN_CMP;
        end
      end

      ST_OWN_CMP: begin
        if (32'(end_rd_q) > 32'(part_q)) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q + 1'b1;
        end
        state_d = ST_OWN_RD;
      end

      ST_LEFT_WR: begin
        // Saturate the owner's count at zero
        left_we = 1'b1;
        left_wa = lo_q;
        left_wd = (left_rd_q == '0) ? '0 : left_rd_q - 1'b1;
        oleft_d = left_wd;
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rp_q        <= '0;
      rt_q        <= '0;
      rpm1_q      <= '0;
      rtm1_q      <= '0;
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      rt_q        <= rt_d;
      rpm1_q      <= rpm1_d;
      rtm1_q      <= rtm1_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cw_q     <= cw_d;
    w0_q     <= w0_d;
    off_q    <= off_d;
    wrap_q   <= wrap_d;
    t_q      <= t_d;
    lparts_q <= lparts_d;
    lthr_q   <= lthr_d;
    offset_q <= offset_d;
    part_q   <= part_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    found_q  <= found_d;
    oleft_q  <= oleft_d;
    if (out_load) begin
      out_found_q <= found_q;
      out_part_q  <= PART_W'(part_q);
      out_owner_q <= OWNER_W'(lo_q);
      out_oleft_q <= LEFT_W'(oleft_q);
      out_pleft_q <= LEFT_W'(pending_q);
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.found           = out_found_q;
  assign rsp_o.partition       = out_part_q;
  assign rsp_o.owner_thread    = out_owner_q;
  assign rsp_o.owner_left      = out_oleft_q;
  assign rsp_o.partitions_left = out_pleft_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Never more unclaimed partitions than the round holds
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pending_q) <= 32'(rp_q))
    else $error("pending count exceeds round partition count");

  // A found bit always lies inside the round
  a_hit_in_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_CHK && scan_hit) |-> {cw_q, scan_idx} <= rpm1_q)
    else $error("scan claimed a partition beyond the round");

  // Each claim takes exactly one from the pending count
  a_claim_decrement: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_CHK && scan_hit) |=>
      (pending_q == $past(pending_q) - 1'b1 && state_q == ST_OWN_RD))
    else $error("claim did not decrement pending count");

  // Owner search window never inverts
  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OWN_RD) |-> (lo_q <= hi_q && hi_q <= rtm1_q))
    else $error("owner search window inverted");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the partition claim dispenser. Requests go in
// through the request channel: new rounds, and claims from threads that
// either resume from the partition they hold or ask for a fresh start. An
// internal model of the claim map and the per-thread ranges forecasts every
// response. Each response is compared field by field with the oldest
// forecast. Directed corners come first, then a flat-out stretch, a long response
// stall, and random rounds over a wide spread of partition and thread counts.
// ----------------------------------------------------------------------------
module tb_top;
  import pcd_pkg::*;

  localparam int unsigned NUM_PARTS   = DEF_MAX_PARTITIONS;
  localparam int unsigned NUM_THREADS = DEF_MAX_THREADS;
  localparam int unsigned IDLE_PCT    = 31;   // chance of an idle cycle on either side
  localparam int unsigned HOLD_CYCLES = 400;  // length of the one long response stall
  localparam int unsigned RANDOM_REQS = 1250;
  localparam logic [PREV_W-1:0] NO_PREV = '1; // out of range for every round

  // One response of the dispenser
  typedef struct packed {
    logic               found;
    logic [PART_W-1:0]  partition;
    logic [OWNER_W-1:0] owner;
    logic [LEFT_W-1:0]  owner_left;
    logic [LEFT_W-1:0]  partitions_left;
  } grant_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  pcd_req_if req_ch ();
  pcd_rsp_if rsp_ch ();

  partition_claim_dispenser_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Model of the dispenser: configuration registers, counts latched at the
  // last new round, claim map and per-thread ranges.
  // --------------------------------------------------------------------------
  int unsigned cfg_parts   = PC_RESET;
  int unsigned cfg_threads = TC_RESET;
  int unsigned live_parts;
  int unsigned live_threads;
  int unsigned partitions_pending;
  bit          taken_map [NUM_PARTS];
  int unsigned span_lo   [NUM_THREADS];
  int unsigned span_hi   [NUM_THREADS];
  int unsigned span_open [NUM_THREADS];

  grant_t expected_grants [$];
  grant_t last_grant;
  grant_t want;

  // Stimulus bookkeeping: last partition each thread got in this round
  logic [PREV_W-1:0] thread_last [NUM_THREADS];

  bit          steady_flow = 1'b0;  // both sides run without idling
  bit          hold_go     = 1'b0;  // start the long response stall
  int unsigned hold_count  = 0;

  int unsigned n_errors  = 0;
  int unsigned n_checked = 0;
  int unsigned n_rounds  = 0;
  int unsigned n_granted = 0;
  int unsigned n_dry     = 0;

  // Work out the response to one request and advance the model.
  function automatic grant_t predict_dispense(pcd_mode_e mode, logic [TID_W-1:0] tid,
                                              logic [PREV_W-1:0] prev);
    grant_t      g;
    int unsigned start, p, i, t, quota, parts_rem, thr_rem, offset;
    g = '0;
    if (mode == MODE_NEW_ROUND) begin
      // Saturate the counts, and treat zero threads as one
      live_parts   = (cfg_parts > NUM_PARTS) ? NUM_PARTS : cfg_parts;
      live_threads = (cfg_threads > NUM_THREADS) ? NUM_THREADS : cfg_threads;
      if (live_threads == 0) begin
        live_threads = 1;
      end
      taken_map          = '{default: 1'b0};
      partitions_pending = live_parts;
      // Hand each thread in turn remaining partitions / remaining threads
      parts_rem = live_parts;
      thr_rem   = live_threads;
      offset    = 0;
      for (t = 0; t < live_threads; t++) begin
        quota        = parts_rem / thr_rem;
        span_lo[t]   = offset;
        offset      += quota;
        span_hi[t]   = offset;
        span_open[t] = quota;
        thr_rem--;
        parts_rem   -= quota;
      end
    end else if (partitions_pending != 0 && live_parts != 0) begin
      // Resume from prev, or from the thread's own range start; a thread
      // outside the round starts at partition zero
      start = prev;
      if (start >= live_parts) begin
        start = (tid < live_threads) ? span_lo[tid] : 0;
      end
      for (i = 0; i < live_parts; i++) begin
        p = start + i;
        if (p >= live_parts) begin
          p -= live_parts;
        end
        if (!taken_map[p]) begin
          taken_map[p] = 1'b1;
          partitions_pending--;
          g.found     = 1'b1;
          g.partition = p;
          for (t = 0; t < live_threads; t++) begin
            if (p < span_hi[t]) begin
              if (span_open[t] != 0) begin
                span_open[t]--;
              end
              g.owner      = t;
              g.owner_left = span_open[t];
              break;
            end
          end
          break;
        end
      end
    end
    g.partitions_left = partitions_pending;
    return g;
  endfunction

  // --------------------------------------------------------------------------
  // Response side: random back-pressure, one long stall on demand.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_go && hold_count < HOLD_CYCLES) begin
      rsp_ch.ready <= 1'b0;
      hold_count   <= hold_count + 1;
    end else if (steady_flow) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      n_errors++;
    end
  endtask

  // Compare every accepted response with the oldest forecast
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: response with nothing expected, expected none, got partition %0d",
                 $time, rsp_ch.partition);
        n_errors++;
      end else begin
        want = expected_grants.pop_front();
        n_checked++;
        check_field("found", want.found, rsp_ch.found);
        check_field("partition", want.partition, rsp_ch.partition);
        check_field("owner_thread", want.owner, rsp_ch.owner_thread);
        check_field("owner_left", want.owner_left, rsp_ch.owner_left);
        check_field("partitions_left", want.partitions_left, rsp_ch.partitions_left);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request, hold it until taken, then record its forecast.
  // Valid stays high after acceptance; the next call drops or reuses it.
  task automatic send_request(pcd_mode_e mode, logic [TID_W-1:0] tid,
                              logic [PREV_W-1:0] prev);
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IDLE_PCT);
    end
    req_ch.valid          <= 1'b1;
    req_ch.mode           <= mode;
    req_ch.thread_id      <= tid;
    req_ch.prev_partition <= prev;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    last_grant = predict_dispense(mode, tid, prev);
    expected_grants.push_back(last_grant);
    if (mode == MODE_NEW_ROUND) begin
      n_rounds++;
      thread_last = '{default: NO_PREV};
    end else if (last_grant.found) begin
      n_granted++;
      thread_last[tid] = last_grant.partition;
    end else begin
      n_dry++;
    end
  endtask

  // Drop valid and wait until every forecast response has been taken
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register; only called while the block is idle
  task automatic write_reg(pcd_cfg_idx_e idx, int unsigned value);
    case (idx)
      CFG_PARTITION_COUNT: begin
        value     = value & ((1 << PC_W) - 1);
        cfg_parts = value;
      end
      default: begin
        value       = value & ((1 << TC_W) - 1);
        cfg_threads = value;
      end
    endcase
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // A claim, mostly well formed: a thread of the round resuming after its
  // last partition or asking for a fresh start; the rest is noise
  task automatic send_claim();
    logic [TID_W-1:0]  tid;
    logic [PREV_W-1:0] prev;
    int unsigned       rsel;
    rsel = $urandom_range(99);
    if (rsel < 80) begin
      tid = $urandom_range(live_threads - 1, 0);
      if (rsel < 55) begin
        prev = thread_last[tid];
      end else if (rsel < 70) begin
        prev = $urandom_range(2047, live_parts);
      end else begin
        prev = (live_parts != 0) ? $urandom_range(live_parts - 1, 0) : '0;
      end
    end else begin
      tid  = $urandom();
      prev = $urandom();
    end
    send_request(MODE_CLAIM, tid, prev);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Claims before the first round find nothing
  task automatic test_claim_before_round();
    send_request(MODE_CLAIM, 6'd0, 11'd0);
    send_request(MODE_CLAIM, 6'd63, NO_PREV);
    settle();
  endtask

  // Round at the reset counts: own range start, resume with wrap, foreign thread
  task automatic test_default_round();
    send_request(MODE_NEW_ROUND, 6'd0, 11'd0);
    send_request(MODE_CLAIM, 6'd0, NO_PREV);
    send_request(MODE_CLAIM, 6'd7, 11'd1024);
    send_request(MODE_CLAIM, 6'd3, 11'd63);
    send_request(MODE_CLAIM, 6'd3, 11'd63);
    send_request(MODE_CLAIM, 6'd40, 11'd1500);
    settle();
  endtask

  // Empty round, oversized counts, zero threads and latched counts
  task automatic test_count_extremes();
    write_reg(CFG_PARTITION_COUNT, 0);
    send_request(MODE_NEW_ROUND, 6'd63, 11'd2047);
    send_request(MODE_CLAIM, 6'd0, 11'd0);
    settle();

    write_reg(CFG_PARTITION_COUNT, 2047);
    write_reg(CFG_THREAD_COUNT, 127);
    send_request(MODE_NEW_ROUND, 6'd0, 11'd0);
    send_request(MODE_CLAIM, 6'd63, NO_PREV);
    send_request(MODE_CLAIM, 6'd0, 11'd1023);
    settle();

    // One partition over 64 threads: every range but the last is empty
    write_reg(CFG_PARTITION_COUNT, 1);
    write_reg(CFG_THREAD_COUNT, 64);
    send_request(MODE_NEW_ROUND, 6'd0, 11'd0);
    send_request(MODE_CLAIM, 6'd0, NO_PREV);
    send_request(MODE_CLAIM, 6'd5, 11'd0);
    settle();

    // New counts must not act before the next round
    write_reg(CFG_PARTITION_COUNT, 5);
    write_reg(CFG_THREAD_COUNT, 0);
    send_request(MODE_CLAIM, 6'd1, 11'd4);
    send_request(MODE_NEW_ROUND, 6'd0, 11'd0);
    send_request(MODE_CLAIM, 6'd1, NO_PREV);
    settle();
  endtask

  // Random rounds: new counts, a new round, then claims until the round runs
  // dry or a cap is hit, with the odd restart in the middle
  task automatic test_random_rounds(int unsigned quota);
    int unsigned sent, n_claims, pc, tc, rsel, k;
    sent = 0;
    while (sent < quota) begin
      rsel = $urandom_range(99);
      if (rsel < 70)      pc = $urandom_range(48, 1);
      else if (rsel < 88) pc = $urandom_range(300, 49);
      else if (rsel < 94) pc = $urandom_range(1024, 301);
      else if (rsel < 97) pc = 0;
      else                pc = $urandom_range(2047, 1025);
      rsel = $urandom_range(99);
      if (rsel < 75)      tc = $urandom_range(16, 1);
      else if (rsel < 90) tc = $urandom_range(64, 17);
      else if (rsel < 94) tc = 0;
      else                tc = $urandom_range(127, 65);
      if ($urandom_range(99) < 85) write_reg(CFG_PARTITION_COUNT, pc);
      if ($urandom_range(99) < 85) write_reg(CFG_THREAD_COUNT, tc);
      send_request(MODE_NEW_ROUND, $urandom(), $urandom());
      sent++;
      n_claims = live_parts + $urandom_range(4, 0);
      if (n_claims > 90) n_claims = $urandom_range(90, 40);
      for (k = 0; k < n_claims && sent < quota; k++) begin
        if ($urandom_range(99) < 3) begin
          send_request(MODE_NEW_ROUND, $urandom(), $urandom());
        end else begin
          send_claim();
        end
        sent++;
      end
      settle();
    end
  endtask

  // Both sides flat out for a whole round
  task automatic test_steady_flow();
    int unsigned k;
    write_reg(CFG_PARTITION_COUNT, 96);
    write_reg(CFG_THREAD_COUNT, 6);
    steady_flow <= 1'b1;
    send_request(MODE_NEW_ROUND, 6'd0, 11'd0);
    for (k = 0; k < 100; k++) send_claim();
    settle();
    steady_flow <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the response side off for a long stretch while requests keep coming
  task automatic test_response_stall();
    int unsigned k;
    write_reg(CFG_PARTITION_COUNT, 300);
    write_reg(CFG_THREAD_COUNT, 12);
    send_request(MODE_NEW_ROUND, 6'd0, 11'd0);
    hold_go <= 1'b1;
    for (k = 0; k < 30; k++) send_claim();
    settle();
  endtask

  initial begin
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = CFG_PARTITION_COUNT;
    cfg_wdata_i           = '0;
    req_ch.valid          = 1'b0;
    req_ch.mode           = MODE_CLAIM;
    req_ch.thread_id      = '0;
    req_ch.prev_partition = '0;
    rsp_ch.ready          = 1'b0;
    thread_last           = '{default: NO_PREV};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_claim_before_round();
    test_default_round();
    test_count_extremes();
    test_steady_flow();
    test_response_stall();
    test_random_rounds(RANDOM_REQS);

    // Let any stray response show up before judging
    settle();
    repeat (64) @(posedge clk_i);

    $display("Checked %0d responses over %0d rounds: %0d partitions granted, %0d dry claims.",
             n_checked, n_rounds, n_granted, n_dry);
    $display("Covered empty and saturated counts, foreign threads, a flat-out round and a long stall.");
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #100ms;
    $display("Run stopped at the time limit with %0d responses outstanding.",
             expected_grants.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
hdl/pcd_pkg.sv
hdl/pcd_if.sv
hdl/pcd_divider.sv
hdl/partition_claim_dispenser_core.sv
tb/tb_top.sv
